// File: hdl/chpp_pkg.sv
// Shared types and constants for the colon-header packet parser.
package chpp_pkg;

    localparam int PAYLOAD_MAX_DEF = 1000;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int COUNT_OUT_W = 16;
    localparam int SIZE_W      = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       message_start;
    } byte_item_t;

    typedef struct packed {
        logic [1:0]             result_kind;
        logic [7:0]             data_byte;
        logic [COUNT_OUT_W-1:0] total_fragments;
        logic [COUNT_OUT_W-1:0] fragment_number;
        logic [SIZE_W-1:0]      payload_size;
        logic                   size_clamped;
        logic                   last;
    } result_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: hdl/colon_header_packet_parser.sv
// Colon-header datagram parser top level: parser front, result queue, output stage.
//
// Input channel byte_*: one datagram byte per beat; message_start marks the first
// byte of a datagram and restarts the parse on that same byte. A datagram reads
// total:fragment:size:filename:payload. Numeric bytes produce no result; each
// filename byte, the header at the fourth colon, and exactly size payload bytes
// each produce one result beat on result_*. last marks the final payload byte or
// a header with zero size. Bytes after the payload are dropped.
// Throughput: one byte per cycle while byte_stall is low. A result is written into
// the queue at the edge that accepts its byte, then moves on into the output
// register once that register is free or its beat leaves.
// The parse state advances once per accepted byte through a decimal
// multiply-by-ten accumulate in the front end.
// Stall: when result_stall holds, the four-entry queue fills and byte_stall rises
// once it is full; bytes that produce no result also wait while it is full.
// Reset: all parse state clears to the start of a datagram and both channels
// go idle; no clearing pass is needed.
module colon_header_packet_parser #(
    parameter int PAYLOAD_MAX = chpp_pkg::PAYLOAD_MAX_DEF,
    parameter int COUNT_WIDTH = chpp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  chpp_pkg::byte_item_t   byte_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output chpp_pkg::result_item_t result_item
);

    chpp_pkg::queue_status_t q_status;
    chpp_pkg::result_item_t  push_item;
    chpp_pkg::result_item_t  pop_item;
    logic                    push;
    logic                    pop;

    chpp_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_item  (push_item)
    );

    chpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    chpp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_item     (pop_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// File: hdl/chpp_front.sv
// Front end: accepts datagram bytes, parses the header and classifies each beat.
module chpp_front #(
    parameter int PAYLOAD_MAX = chpp_pkg::PAYLOAD_MAX_DEF,
    parameter int COUNT_WIDTH = chpp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  chpp_pkg::byte_item_t   byte_item,
    input  chpp_pkg::queue_status_t q_status,
    output logic                   push,
    output chpp_pkg::result_item_t push_item
);

    localparam int PW    = COUNT_WIDTH + 4;
    localparam int CMP_W = (COUNT_WIDTH > chpp_pkg::SIZE_W) ? COUNT_WIDTH : chpp_pkg::SIZE_W;
    localparam int OW    = chpp_pkg::COUNT_OUT_W;
    localparam int SW    = chpp_pkg::SIZE_W;

    typedef enum logic [5:0] {
        FLD_TOTAL = 6'b000001,
        FLD_FRAG  = 6'b000010,
        FLD_SIZE  = 6'b000100,
        FLD_NAME  = 6'b001000,
        FLD_DATA  = 6'b010000,
        FLD_DONE  = 6'b100000
    } field_t;

    field_t                 field_reg, field_next, field_cur;
    logic [COUNT_WIDTH-1:0] acc_reg, acc_next, acc_cur;
    logic                   ended_reg, ended_next, ended_cur;
    logic [OW-1:0]          total_reg, total_next, total_cur;
    logic [OW-1:0]          frag_reg, frag_next, frag_cur;
    logic [SW-1:0]          size_reg, size_next, size_cur;
    logic [SW-1:0]          remain_reg, remain_next, remain_cur;
    logic                   clamp_reg, clamp_next, clamp_cur;

    logic                   accept;
    logic                   start;
    logic                   is_colon;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [PW-1:0]          product;
    logic [COUNT_WIDTH-1:0] acc_digit;
    logic                   size_over;
    logic [SW-1:0]          remain_dec;
    logic                   has_result;
    chpp_pkg::result_item_t res;

    assign byte_stall = q_status.full;
    assign accept     = byte_valid && !byte_stall;
    assign start      = byte_item.message_start;
    assign is_colon   = (byte_item.byte_value == chpp_pkg::COLON_CHAR);
    assign is_digit   = (byte_item.byte_value >= chpp_pkg::DIGIT_ZERO) &&
                        (byte_item.byte_value <= chpp_pkg::DIGIT_NINE);
    assign digit      = 4'(byte_item.byte_value - chpp_pkg::DIGIT_ZERO);

    // A start beat parses against the reset state
    assign field_cur  = start ? FLD_TOTAL : field_reg;
    assign acc_cur    = start ? '0 : acc_reg;
    assign ended_cur  = start ? 1'b0 : ended_reg;
    assign total_cur  = start ? '0 : total_reg;
    assign frag_cur   = start ? '0 : frag_reg;
    assign size_cur   = start ? '0 : size_reg;
    assign remain_cur = start ? '0 : remain_reg;
    assign clamp_cur  = start ? 1'b0 : clamp_reg;

    // acc * 10 + digit, saturating at the counter width
    assign product    = (PW'(acc_cur) << 3) + (PW'(acc_cur) << 1) + PW'(digit);
    assign acc_digit  = (|product[PW-1:COUNT_WIDTH]) ? '1 : product[COUNT_WIDTH-1:0];
    assign size_over  = CMP_W'(acc_cur) > CMP_W'(PAYLOAD_MAX);
    assign remain_dec = remain_cur - 1'b1;

    always_comb
    begin
        field_next  = field_cur;
        acc_next    = acc_cur;
        ended_next  = ended_cur;
        total_next  = total_cur;
        frag_next   = frag_cur;
        size_next   = size_cur;
        remain_next = remain_cur;
        clamp_next  = clamp_cur;
        has_result  = 1'b0;
        res.result_kind     = chpp_pkg::KIND_NAME;
        res.data_byte       = byte_item.byte_value;
        res.total_fragments = total_cur;
        res.fragment_number = frag_cur;
        res.payload_size    = size_cur;
        res.size_clamped    = clamp_cur;
        res.last            = 1'b0;
        case (field_cur)
            FLD_TOTAL, FLD_FRAG, FLD_SIZE:
            begin
                if (is_colon)
                begin
                    if (field_cur == FLD_TOTAL)
                    begin
                        total_next = OW'(acc_cur);
                        field_next = FLD_FRAG;
                    end
                    else if (field_cur == FLD_FRAG)
                    begin
                        frag_next  = OW'(acc_cur);
                        field_next = FLD_SIZE;
                    end
                    else
                    begin
                        clamp_next = size_over;
                        size_next  = size_over ? SW'(PAYLOAD_MAX) : SW'(acc_cur);
                        field_next = FLD_NAME;
                    end
                    acc_next   = '0;
                    ended_next = 1'b0;
                end
                else if (!ended_cur)
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_digit;
                    end
                    else
                    begin
                        ended_next = 1'b1;
                    end
                end
            end
            FLD_NAME:
            begin
                has_result = 1'b1;
                if (is_colon)
                begin
                    res.result_kind = chpp_pkg::KIND_HEADER;
                    res.data_byte   = '0;
                    remain_next     = size_cur;
                    if (size_cur == '0)
                    begin
                        res.last   = 1'b1;
                        field_next = FLD_DONE;
                    end
                    else
                    begin
                        field_next = FLD_DATA;
                    end
                end
            end
            FLD_DATA:
            begin
                has_result      = 1'b1;
                res.result_kind = chpp_pkg::KIND_PAYLOAD;
                remain_next     = remain_dec;
                if (remain_dec == '0)
                begin
                    res.last   = 1'b1;
                    field_next = FLD_DONE;
                end
            end
            default:
            begin
                // drop bytes past the payload
                has_result = 1'b0;
            end
        endcase
    end

    assign push      = accept && has_result;
    assign push_item = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg  <= FLD_TOTAL;
            acc_reg    <= '0;
            ended_reg  <= 1'b0;
            total_reg  <= '0;
            frag_reg   <= '0;
            size_reg   <= '0;
            remain_reg <= '0;
            clamp_reg  <= 1'b0;
        end
        else if (accept)
        begin
            field_reg  <= field_next;
            acc_reg    <= acc_next;
            ended_reg  <= ended_next;
            total_reg  <= total_next;
            frag_reg   <= frag_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
            clamp_reg  <= clamp_next;
        end
    end

`ifndef SYNTHESIS
    a_field_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(field_reg))
        else $error("field state lost its one-hot code");
    a_data_remain : assert property (@(posedge clk) disable iff (!rst_n)
        (field_reg == FLD_DATA) |-> (remain_reg != '0))
        else $error("payload state with nothing left to pass");
    a_size_limit : assert property (@(posedge clk) disable iff (!rst_n)
        SW'(size_reg) <= SW'(PAYLOAD_MAX))
        else $error("parsed size above the payload limit");
`endif

endmodule

// File: hdl/chpp_queue.sv
// Short result queue between the parser front end and the output stage.
module chpp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  chpp_pkg::result_item_t  push_item,
    input  logic                    pop,
    output chpp_pkg::result_item_t  pop_item,
    output chpp_pkg::queue_status_t status
);

    localparam int DEPTH = chpp_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    chpp_pkg::result_item_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = mem[rd_ptr_reg];

    assign wr_ptr_next = push ? ((wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1)
                              : wr_ptr_reg;
    assign rd_ptr_next = pop ? ((rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1)
                             : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into a full queue");
    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from an empty queue");
    a_count_up : assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// File: hdl/chpp_back.sv
// Back end: drains the result queue into the registered output channel.
module chpp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  chpp_pkg::queue_status_t q_status,
    input  chpp_pkg::result_item_t  pop_item,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output chpp_pkg::result_item_t  result_item
);

    logic                   valid_reg, valid_next;
    chpp_pkg::result_item_t item_reg;
    logic                   load;

    // Load when the output register is free or its beat leaves this cycle
    assign load       = !valid_reg || !result_stall;
    assign pop        = load && !q_status.empty;
    assign valid_next = load ? !q_status.empty : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= pop_item;
        end
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

`ifndef SYNTHESIS
    a_pop_loads : assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg)
        else $error("popped beat not presented");
    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_stall) |-> !pop)
        else $error("queue popped while output stalled");
    a_drain : assert property (@(posedge clk) disable iff (!rst_n)
        (!valid_reg && !q_status.empty) |-> pop)
        else $error("idle output with a waiting beat");
`endif

endmodule

// File: bench/chpp_parse_monitor.sv
// Parse monitor: tracks accepted bytes, predicts parser results and compares them.
`timescale 1ns / 1ps

module chpp_parse_monitor #(
    parameter int PAYLOAD_LIMIT = chpp_pkg::PAYLOAD_MAX_DEF,
    parameter int NUM_WIDTH     = chpp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic                   byte_stall,
    input  chpp_pkg::byte_item_t   byte_item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  chpp_pkg::result_item_t result_item,
    output int                     error_count,
    output int                     outstanding,
    output int                     beats_taken,
    output int                     results_checked,
    output int                     headers_checked,
    output int                     clamped_headers
);

    localparam int OW = chpp_pkg::COUNT_OUT_W;
    localparam int SW = chpp_pkg::SIZE_W;
    localparam logic [63:0] COUNT_CEIL = (64'd1 << NUM_WIDTH) - 64'd1;

    typedef enum logic [2:0] {
        FLD_TOTAL,
        FLD_FRAGMENT,
        FLD_SIZE,
        FLD_NAME,
        FLD_PAYLOAD,
        FLD_DONE
    } parse_field_t;

    parse_field_t           field_at;
    logic [63:0]            digit_acc;
    logic                   number_closed;
    logic [OW-1:0]          total_seen;
    logic [OW-1:0]          fragment_seen;
    logic [SW-1:0]          size_seen;
    logic [SW-1:0]          bytes_left;
    logic                   clamp_seen;
    chpp_pkg::result_item_t awaited_results[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] result %0d: %s got 0x%0h, predicted 0x%0h",
                 $time, results_checked, what, got, want);
        error_count++;
    endtask

    task automatic clear_parse();
        field_at      = FLD_TOTAL;
        digit_acc     = '0;
        number_closed = 1'b0;
        total_seen    = '0;
        fragment_seen = '0;
        size_seen     = '0;
        bytes_left    = '0;
        clamp_seen    = 1'b0;
    endtask

    function automatic chpp_pkg::result_item_t form_result(input logic [1:0] kind,
                                                           input logic [7:0] data,
                                                           input logic fin);
        chpp_pkg::result_item_t r;
        r.result_kind     = kind;
        r.data_byte       = data;
        r.total_fragments = total_seen;
        r.fragment_number = fragment_seen;
        r.payload_size    = size_seen;
        r.size_clamped    = clamp_seen;
        r.last            = fin;
        return r;
    endfunction

    task automatic parse_byte(input chpp_pkg::byte_item_t beat);
        logic [7:0]  b;
        logic [63:0] next_acc;
        b = beat.byte_value;
        if (beat.message_start)
            clear_parse();
        if (field_at < FLD_NAME)
        begin
            if (b == chpp_pkg::COLON_CHAR)
            begin
                case (field_at)
                    FLD_TOTAL:    total_seen = digit_acc[OW-1:0];
                    FLD_FRAGMENT: fragment_seen = digit_acc[OW-1:0];
                    default:
                    begin
                        if (digit_acc > PAYLOAD_LIMIT)
                        begin
                            size_seen  = SW'(PAYLOAD_LIMIT);
                            clamp_seen = 1'b1;
                        end
                        else
                        begin
                            size_seen  = digit_acc[SW-1:0];
                            clamp_seen = 1'b0;
                        end
                    end
                endcase
                digit_acc     = '0;
                number_closed = 1'b0;
                field_at      = parse_field_t'(field_at + 3'd1);
            end
            else if (!number_closed)
            begin
                if (b >= chpp_pkg::DIGIT_ZERO && b <= chpp_pkg::DIGIT_NINE)
                begin
                    next_acc  = digit_acc * 64'd10 + 64'(b - chpp_pkg::DIGIT_ZERO);
                    digit_acc = (next_acc > COUNT_CEIL) ? COUNT_CEIL : next_acc;
                end
                else
                begin
                    // first non-digit ends the number; ignore the rest up to the colon
                    number_closed = 1'b1;
                end
            end
        end
        else if (field_at == FLD_NAME)
        begin
            if (b == chpp_pkg::COLON_CHAR)
            begin
                bytes_left = size_seen;
                if (bytes_left == '0)
                begin
                    field_at = FLD_DONE;
                    awaited_results.push_back(
                        form_result(chpp_pkg::KIND_HEADER, 8'h00, 1'b1));
                end
                else
                begin
                    field_at = FLD_PAYLOAD;
                    awaited_results.push_back(
                        form_result(chpp_pkg::KIND_HEADER, 8'h00, 1'b0));
                end
            end
            else
            begin
                awaited_results.push_back(form_result(chpp_pkg::KIND_NAME, b, 1'b0));
            end
        end
        else if (field_at == FLD_PAYLOAD)
        begin
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0)
                field_at = FLD_DONE;
            awaited_results.push_back(
                form_result(chpp_pkg::KIND_PAYLOAD, b, bytes_left == '0));
        end
    endtask

    task automatic check_result(input chpp_pkg::result_item_t got);
        chpp_pkg::result_item_t want;
        results_checked++;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("result with nothing pending", 64'(got), 64'd0);
            return;
        end
        want = awaited_results.pop_front();
        if (got.result_kind !== want.result_kind)
            report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
        if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", 64'(got.data_byte), 64'(want.data_byte));
        if (got.total_fragments !== want.total_fragments)
            report_mismatch("total_fragments", 64'(got.total_fragments),
                            64'(want.total_fragments));
        if (got.fragment_number !== want.fragment_number)
            report_mismatch("fragment_number", 64'(got.fragment_number),
                            64'(want.fragment_number));
        if (got.payload_size !== want.payload_size)
            report_mismatch("payload_size", 64'(got.payload_size),
                            64'(want.payload_size));
        if (got.size_clamped !== want.size_clamped)
            report_mismatch("size_clamped", 64'(got.size_clamped),
                            64'(want.size_clamped));
        if (got.last !== want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
        if (want.result_kind == chpp_pkg::KIND_HEADER)
        begin
            headers_checked++;
            if (want.size_clamped)
                clamped_headers++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_parse();
            awaited_results.delete();
        end
        else
        begin
            if (byte_valid && !byte_stall)
            begin
                beats_taken++;
                parse_byte(byte_item);
            end
            if (result_valid && !result_stall)
                check_result(result_item);
        end
        outstanding = awaited_results.size();
    end

endmodule

// File: bench/colon_header_packet_parser_test.sv
// Top of the parser bench: clock, reset, datagram stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module colon_header_packet_parser_test;

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    logic                   clk;
    logic                   rst_n;
    logic                   byte_valid;
    logic                   byte_stall;
    chpp_pkg::byte_item_t   byte_item;
    logic                   result_valid;
    logic                   result_stall;
    chpp_pkg::result_item_t result_item;

    int error_count;
    int outstanding;
    int beats_taken;
    int results_checked;
    int headers_checked;
    int clamped_headers;

    logic [7:0]           dgram_bytes[$];
    chpp_pkg::byte_item_t stim_beats[$];
    int                   datagrams_sent;
    int                   broken_sent;
    int                   holds_done;
    bit                   hold_request;

    colon_header_packet_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    chpp_parse_monitor parse_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .byte_item       (byte_item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_item     (result_item),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .beats_taken     (beats_taken),
        .results_checked (results_checked),
        .headers_checked (headers_checked),
        .clamped_headers (clamped_headers)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic append_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            dgram_bytes.push_back(s[i]);
    endtask

    task automatic commit_datagram(input bit with_start, input int keep);
        chpp_pkg::byte_item_t beat;
        int                   i;
        for (i = 0; i < keep && i < dgram_bytes.size(); i++)
        begin
            beat.byte_value    = dgram_bytes[i];
            beat.message_start = with_start && (i == 0);
            stim_beats.push_back(beat);
        end
        dgram_bytes.delete();
        datagrams_sent++;
    endtask

    function automatic string count_text();
        case ($urandom_range(0, 7))
            0:       return "";
            1:       return $sformatf("%0d", $urandom_range(0, 9));
            2, 3:    return $sformatf("%0d", $urandom_range(0, 999));
            4:       return $sformatf("%0d", $urandom_range(0, 65535));
            5:       return $sformatf("%0d%0d", $urandom_range(1, 9999), $urandom);
            6:       return $sformatf("%0dz%0d", $urandom_range(0, 99), $urandom_range(0, 9));
            default: return $sformatf("-%0d", $urandom_range(0, 99));
        endcase
    endfunction

    task automatic pick_size(output string txt, output int unsigned value);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            value = $urandom_range(0, 12);
        else if (roll < 80)
            value = $urandom_range(13, 40);
        else if (roll < 86)
            value = $urandom_range(999, 1001);
        else if (roll < 92)
            value = $urandom_range(1002, 99999);
        else
            value = $urandom_range(0, 9);
        if (roll >= 92)
            txt = $sformatf("%0d/%0d", value, $urandom_range(0, 9));
        else
            txt = $sformatf("%0d", value);
        if ($urandom_range(0, 15) == 0)
            txt = {"0", txt};
    endtask

    task automatic add_random_datagram();
        int unsigned roll;
        int unsigned size_value;
        int unsigned span;
        int unsigned i;
        string       size_txt;
        logic [7:0]  b;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            // raw noise, sometimes continuing whatever state the parser is in
            span = $urandom_range(1, 12);
            for (i = 0; i < span; i++)
                dgram_bytes.push_back(($urandom_range(0, 3) == 0) ? chpp_pkg::COLON_CHAR
                                                                  : 8'($urandom));
            broken_sent++;
            commit_datagram(1'($urandom_range(0, 1)), dgram_bytes.size());
            return;
        end
        append_text(count_text());
        dgram_bytes.push_back(chpp_pkg::COLON_CHAR);
        append_text(count_text());
        dgram_bytes.push_back(chpp_pkg::COLON_CHAR);
        pick_size(size_txt, size_value);
        append_text(size_txt);
        dgram_bytes.push_back(chpp_pkg::COLON_CHAR);
        span = $urandom_range(0, 6);
        for (i = 0; i < span; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == chpp_pkg::COLON_CHAR)
                b = 8'h00;
            dgram_bytes.push_back(b);
        end
        dgram_bytes.push_back(chpp_pkg::COLON_CHAR);
        // cut long payloads short; the next datagram start restarts the parse
        span = (size_value <= 40) ? size_value : $urandom_range(0, 24);
        for (i = 0; i < span; i++)
            dgram_bytes.push_back(($urandom_range(0, 7) == 0) ? chpp_pkg::COLON_CHAR
                                                              : 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
        begin
            span = $urandom_range(1, 3);
            for (i = 0; i < span; i++)
                dgram_bytes.push_back(8'($urandom));
        end
        if (roll < 18)
        begin
            broken_sent++;
            commit_datagram(1'b1, $urandom_range(1, dgram_bytes.size()));
        end
        else
        begin
            commit_datagram(1'b1, dgram_bytes.size());
        end
    endtask

    // receiver: random stall per result, calm stretches, and long holds on request
    initial
    begin : result_drain
        int unsigned pause;
        int          taken;
        taken        = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            pause = (((taken / 80) % 3) == 1) ? 0 : $urandom_range(0, 19);
            if (pause > 0)
            begin
                result_stall <= 1'b1;
                repeat (pause) @(negedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still pending", cycles, outstanding);
        $display("colon_header_packet_parser_test: errors");
        $finish;
    end

    initial
    begin : byte_feed
        int          directed_count;
        int          idx;
        int unsigned gap;
        rst_n          = 1'b0;
        byte_valid     = 1'b0;
        byte_item      = '0;
        hold_request   = 1'b0;
        datagrams_sent = 0;
        broken_sent    = 0;
        holds_done     = 0;

        // no start flag after reset; bad digit, bare sign, zero size, trailing byte
        append_text("7x:-:0::Z");
        commit_datagram(1'b0, dgram_bytes.size());
        // saturated total, top fragment, oversized size, NUL name, cut mid-payload
        append_text("99999:65535:1001:");
        dgram_bytes.push_back(8'h00);
        dgram_bytes.push_back(chpp_pkg::COLON_CHAR);
        dgram_bytes.push_back(8'hFF);
        commit_datagram(1'b1, dgram_bytes.size());
        // one-byte payload marked last, then a byte to drop
        append_text("1:0:1:a:");
        dgram_bytes.push_back(8'h00);
        dgram_bytes.push_back(8'hC3);
        commit_datagram(1'b1, dgram_bytes.size());
        directed_count = stim_beats.size();
        while (stim_beats.size() < directed_count + RANDOM_ITEMS)
            add_random_datagram();

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        for (idx = 0; idx < stim_beats.size(); idx++)
        begin
            if (idx == directed_count + 50 || idx == directed_count + 450)
                hold_request = 1'b1;
            gap = (((idx / 96) % 3) == 1) ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            byte_item  <= stim_beats[idx];
            byte_valid <= 1'b1;
            @(posedge clk);
            while (byte_stall)
                @(posedge clk);
            @(negedge clk);
        end
        byte_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d datagrams (%0d cut short or noise), %0d byte beats accepted",
                 datagrams_sent, broken_sent, beats_taken);
        $display("checked %0d results: %0d headers, %0d with clamped size, %0d long holds",
                 results_checked, headers_checked, clamped_headers, holds_done);
        if (error_count == 0)
            $display("colon_header_packet_parser_test: clean");
        else
            $display("colon_header_packet_parser_test: errors");
        $finish;
    end

endmodule
